// ===== rtl/rlcc_pkg.sv =====
// rlcc_pkg: shared widths, radix, operation codes, controller states and the
// command/status structs of the radix limb carry chain ALU.
// No dependencies.
package rlcc_pkg;

  localparam int LIMB_W = 27;
  localparam int WORD_W = 32;
  localparam int EXT_W  = WORD_W + 1;
  localparam int DIV_W  = 60;              // covers u*n+c and c*RADIX+u
  localparam int ITER_N = DIV_W / 2;       // two quotient bits per cycle
  localparam int CNT_W  = $clog2(ITER_N);

  localparam logic [WORD_W-1:0] RADIX = 32'd100000000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_PREP,
    ST_ITER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic prep;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic iter_last;
  } dp_stat_t;

endpackage

// ===== rtl/rlcc_if.sv =====
// rlcc_in_if / rlcc_out_if: valid/ready channels for input and result words.
// Depends on rlcc_pkg.
interface rlcc_in_if;
  import rlcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [LIMB_W-1:0] limb_u;
  logic [LIMB_W-1:0] limb_v;
  logic              first_limb;
  logic              last_limb;

  modport source (output valid, cmd, limb_u, limb_v, first_limb, last_limb,
                  input ready);
  modport sink   (input valid, cmd, limb_u, limb_v, first_limb, last_limb,
                  output ready);
endinterface

interface rlcc_out_if;
  import rlcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] result_limb;
  logic [WORD_W-1:0] final_carry;
  logic              run_done;

  modport source (output valid, result_limb, final_carry, run_done, input ready);
  modport sink   (input valid, result_limb, final_carry, run_done, output ready);
endinterface

// ===== rtl/rlcc_ctrl.sv =====
// rlcc_ctrl: sequencer for one word: capture, multiply, prepare, divide loop,
// result write. Owns the handshake flags. Depends on rlcc_pkg.
module rlcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rlcc_pkg::dp_stat_t   stat,
  output rlcc_pkg::ctrl_cmd_t  cmd
);
  import rlcc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (stat.iter_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rlcc_dp.sv =====
// rlcc_dp: operand capture, 32x32 multiplier, dividend setup, radix-4
// restoring divider, result forming, running carry and n register.
// Depends on rlcc_pkg.
module rlcc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlcc_pkg::ctrl_cmd_t          cmd,
  output rlcc_pkg::dp_stat_t           stat,
  input  logic                         cfg_wr_en,
  input  logic [rlcc_pkg::WORD_W-1:0]  cfg_wr_data,
  input  logic [1:0]                   in_cmd,
  input  logic [rlcc_pkg::LIMB_W-1:0]  in_limb_u,
  input  logic [rlcc_pkg::LIMB_W-1:0]  in_limb_v,
  input  logic                         in_first_limb,
  input  logic                         in_last_limb,
  output logic [rlcc_pkg::LIMB_W-1:0]  out_result_limb,
  output logic [rlcc_pkg::WORD_W-1:0]  out_final_carry,
  output logic                         out_run_done
);
  import rlcc_pkg::*;

  logic [WORD_W-1:0] n_r;
  logic [WORD_W-1:0] carry_r, carry_nxt;

  op_t               op_r;
  logic [LIMB_W-1:0] u_r, v_r;
  logic              last_r;
  logic [WORD_W-1:0] c_r;

  logic [DIV_W-1:0]  prod_r;
  logic [EXT_W-1:0]  take_r;
  logic              neg_r;

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [LIMB_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] fc_r;
  logic              done_r;

  // multiplier: u*n for multiply, carry*RADIX for divide
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] prod_full;

  always_comb begin
    if (op_r == OP_DIV) begin
      mul_a = c_r;
      mul_b = RADIX;
    end else begin
      mul_a = WORD_W'(u_r);
      mul_b = n_r;
    end
    prod_full = mul_a * mul_b;
  end

  // dividend setup
  logic [EXT_W-1:0] u_ext, diff;
  logic             neg;
  logic [DIV_W-1:0] dividend;
  logic [WORD_W-1:0] divisor;

  always_comb begin
    u_ext   = EXT_W'(u_r);
    neg     = u_ext < take_r;
    diff    = neg ? (take_r - u_ext) : (u_ext - take_r);
    divisor = RADIX;
    case (op_r)
      OP_ADD:  dividend = DIV_W'(u_r) + DIV_W'(v_r) + DIV_W'(c_r);
      OP_SUB:  dividend = DIV_W'(diff);
      OP_MUL:  dividend = prod_r + DIV_W'(c_r);
      OP_DIV: begin
        dividend = prod_r + DIV_W'(u_r);
        divisor  = n_r;
      end
      default: dividend = '0;
    endcase
  end

  // two restoring steps per cycle
  logic [EXT_W-1:0]  t1, t2;
  logic [WORD_W-1:0] r1;
  logic              q1, q0;

  always_comb begin
    t1 = {rem_r, quo_r[DIV_W-1]};
    if (t1 >= {1'b0, dvs_r}) begin
      r1 = WORD_W'(t1 - {1'b0, dvs_r});
      q1 = 1'b1;
    end else begin
      r1 = t1[WORD_W-1:0];
      q1 = 1'b0;
    end
    t2 = {r1, quo_r[DIV_W-2]};
    if (t2 >= {1'b0, dvs_r}) begin
      rem_nxt = WORD_W'(t2 - {1'b0, dvs_r});
      q0      = 1'b1;
    end else begin
      rem_nxt = t2[WORD_W-1:0];
      q0      = 1'b0;
    end
    quo_nxt = {quo_r[DIV_W-3:0], q1, q0};
  end

  // result forming
  always_comb begin
    res_nxt   = rem_r[LIMB_W-1:0];
    carry_nxt = quo_r[WORD_W-1:0];
    case (op_r)
      OP_ADD: ;
      OP_SUB: begin
        carry_nxt = WORD_W'(neg_r);
        if (neg_r && (rem_r != '0)) res_nxt = LIMB_W'(RADIX - rem_r);
      end
      OP_MUL: begin
        if (quo_r[DIV_W-1:WORD_W] != '0) carry_nxt = '1;
      end
      OP_DIV: begin
        if (n_r[WORD_W-1:1] == '0) begin
          res_nxt   = u_r;
          carry_nxt = '0;
        end else begin
          res_nxt   = quo_r[LIMB_W-1:0];
          carry_nxt = rem_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= WORD_W'(1);
      carry_r <= '0;
    end else begin
      if (cfg_wr_en) n_r <= cfg_wr_data;
      if (cmd.finish) carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_cmd);
      u_r    <= in_limb_u;
      v_r    <= in_limb_v;
      last_r <= in_last_limb;
      c_r    <= in_first_limb ? '0 : carry_r;
    end
    if (cmd.mult) begin
      prod_r <= prod_full[DIV_W-1:0];
      take_r <= EXT_W'(v_r) + EXT_W'(c_r);
    end
    if (cmd.prep) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= neg;
      cnt_r <= CNT_W'(ITER_N - 1);
    end
    if (cmd.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.finish) begin
      res_r  <= res_nxt;
      fc_r   <= carry_nxt;
      done_r <= last_r;
    end
  end

  assign stat.iter_last  = (cnt_r == '0);
  assign out_result_limb = res_r;
  assign out_final_carry = fc_r;
  assign out_run_done    = done_r;

endmodule

// ===== rtl/radix_limb_carry_chain_alu.sv =====
// radix_limb_carry_chain_alu: top level, one limb of a radix 10^8 carry chain.
// Depends on rlcc_pkg, rlcc_if, rlcc_ctrl, rlcc_dp.
//
//  channel | dir | handshake          | contents
//  in_ch   | in  | valid/ready        | cmd, limb_u, limb_v, first_limb, last_limb
//  out_ch  | out | valid/ready        | result_limb, final_carry, run_done
//  cfg     | in  | cfg_wr_en, no wait | small_operand n (32 bits, reset 1)
//
// One word at a time: from accept the word passes the multiply and setup states and
// the two-bit-per-cycle divider loop before the result is in the output register.
// The next word is taken in the cycle after the result is written, even if
// out_ch has not taken it, so no word overlaps another; a result waits
// in the done state while the output register is still full.
// Reset is synchronous: carry 0, n 1.
module radix_limb_carry_chain_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  rlcc_in_if.sink                     in_ch,
  rlcc_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [rlcc_pkg::WORD_W-1:0] cfg_wr_data
);
  import rlcc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rlcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlcc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_ch.cmd),
    .in_limb_u       (in_ch.limb_u),
    .in_limb_v       (in_ch.limb_v),
    .in_first_limb   (in_ch.first_limb),
    .in_last_limb    (in_ch.last_limb),
    .out_result_limb (out_ch.result_limb),
    .out_final_carry (out_ch.final_carry),
    .out_run_done    (out_ch.run_done)
  );

endmodule

// ===== rtl/rlcc_chk.sv =====
// rlcc_chk: port-level checks for radix_limb_carry_chain_alu, bound to the top.
// Depends on rlcc_pkg.
module rlcc_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rlcc_pkg::LIMB_W-1:0] result_limb,
  input logic [rlcc_pkg::WORD_W-1:0] final_carry,
  input logic                        run_done
);
  import rlcc_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result_limb) && $stable(final_carry)
                                && $stable(run_done))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !$rose(out_valid))
    else $error("result appeared right after a word was taken");

endmodule

bind radix_limb_carry_chain_alu rlcc_chk u_rlcc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_limb (out_ch.result_limb),
  .final_carry (out_ch.final_carry),
  .run_done    (out_ch.run_done)
);
